>>> design/crcc_pkg.sv
`default_nettype none
package crcc_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_W     = 51;
  localparam int unsigned FIELD_IDX_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMP_LEQ = 2'd0,
    CMP_GT  = 2'd1,
    CMP_EQ  = 2'd2,
    CMP_NEQ = 2'd3
  } cmp_t;

  typedef struct packed {
    logic       en;
    cmp_t       cmp;
    logic [15:0] idx;
    logic [31:0] thr;
  } cond_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic unord;
  } fcmp_t;

  // ieee single compare of a against b
  function automatic fcmp_t fcmp(input logic [31:0] a, input logic [31:0] b);
    fcmp_t r;
    logic  a_nan;
    logic  b_nan;
    logic  a_zero;
    logic  b_zero;
    logic  mag_lt;
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    mag_lt = a[30:0] < b[30:0];
    r.unord = a_nan || b_nan;
    r.eq    = !r.unord && ((a == b) || (a_zero && b_zero));
    if (r.unord || r.eq) begin
      r.lt = 1'b0;
    end else if (a[31] != b[31]) begin
      r.lt = a[31];
    end else if (a[31]) begin
      r.lt = b[30:0] < a[30:0];
    end else begin
      r.lt = mag_lt;
    end
    return r;
  endfunction

  // verdict of one comparator, nan passes everything but eq
  function automatic logic cond_holds(input cmp_t c, input logic [31:0] v,
                                      input logic [31:0] t);
    fcmp_t r;
    logic  h;
    r = fcmp(v, t);
    case (c)
      CMP_LEQ: h = r.unord || r.lt || r.eq;
      CMP_GT:  h = r.unord || !(r.lt || r.eq);
      CMP_EQ:  h = r.eq;
      CMP_NEQ: h = !r.eq;
      default: h = 1'b0;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

>>> design/crcc_cfg_regs.sv
`default_nettype none
module crcc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [crcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic                                cfg_index_hi,
  input  wire logic [crcc_pkg::REG_W-1:0]          cfg_data,
  output crcc_pkg::cond_t                          conds [crcc_pkg::NUM_REGS]
);

  logic [crcc_pkg::REG_W-1:0] regs [crcc_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(crcc_pkg::NUM_REGS); i++) regs[i] <= '0;
    end else if (cfg_valid && !cfg_index_hi) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(crcc_pkg::NUM_REGS); i++) begin
      conds[i] = crcc_pkg::cond_t'(regs[i]);
    end
  end

endmodule
`default_nettype wire

>>> design/crcc_match.sv
`default_nettype none
module crcc_match #(
  parameter int unsigned MAX_CONDITIONS = 8,
  parameter int unsigned INDEX_BITS     = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire crcc_pkg::cond_t              conds [crcc_pkg::NUM_REGS],
  input  wire logic                         step,
  input  wire logic [INDEX_BITS-1:0]        idx,
  input  wire logic [31:0]                  value,
  input  wire logic                         has_feature,
  input  wire logic                         last,
  output logic                              res_set,
  output logic                              res_covered
);

  localparam int unsigned N = crcc_pkg::NUM_REGS;
  localparam int unsigned CMP_W = (INDEX_BITS < crcc_pkg::FIELD_IDX_W) ?
                                  INDEX_BITS : crcc_pkg::FIELD_IDX_W;

  logic [N-1:0] cond_seen;
  logic [N-1:0] cond_pass;
  logic [N-1:0] seen_next;
  logic [N-1:0] pass_next;
  logic [N-1:0] ok;
  logic [N-1:0] en;
  logic         cov;

  always_comb begin
    seen_next = cond_seen;
    pass_next = cond_pass;
    for (int i = 0; i < int'(N); i++) begin
      en[i] = (i < int'(MAX_CONDITIONS)) && conds[i].en;
      if (has_feature && en[i] && (conds[i].idx[CMP_W-1:0] == idx[CMP_W-1:0])) begin
        seen_next[i] = 1'b1;
        pass_next[i] = crcc_pkg::cond_holds(conds[i].cmp, value, conds[i].thr);
      end
      ok[i] = !en[i] || (seen_next[i] ? pass_next[i] :
              crcc_pkg::cond_holds(conds[i].cmp, 32'd0, conds[i].thr));
    end
    cov = &ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cond_seen <= '0;
      cond_pass <= '0;
    end else if (step) begin
      cond_seen <= last ? '0 : seen_next;
      cond_pass <= last ? '0 : pass_next;
    end
  end

  assign res_set     = step && last;
  assign res_covered = cov;

endmodule
`default_nettype wire

>>> design/conjunctive_rule_cover_check.sv
`default_nettype none
// conjunctive rule cover check: tells whether one streamed example meets every
// enabled condition of a rule body (up to eight conditions, each a feature
// index, a comparator and a float32 threshold compared with ieee rules).
// features arrive one beat per cycle; every condition is checked against each
// beat in parallel, so the block takes a beat every clock unless the output
// stalls. the beat marked last gives one covered beat out on the following
// cycle; missing features count as +0.0, a repeated index keeps the later
// verdict. config writes should only be made while no example is in flight.
module conjunctive_rule_cover_check #(
  parameter int unsigned MAX_CONDITIONS = 8,
  parameter int unsigned INDEX_BITS     = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [INDEX_BITS-1:0] feature_index,
  input  wire logic [31:0]           feature_value,
  input  wire logic                  has_feature,
  input  wire logic                  last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       covered,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [31:0]           cfg_index,
  input  wire logic [63:0]           cfg_data
);

  crcc_pkg::cond_t conds [crcc_pkg::NUM_REGS];
  logic step;
  logic res_set;
  logic res_covered;

  // result register frees up in the same cycle it is taken
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  crcc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index[crcc_pkg::CFG_IDX_W-1:0]),
    .cfg_index_hi (|cfg_index[31:crcc_pkg::CFG_IDX_W]),
    .cfg_data     (cfg_data[crcc_pkg::REG_W-1:0]),
    .conds        (conds)
  );

  crcc_match #(
    .MAX_CONDITIONS (MAX_CONDITIONS),
    .INDEX_BITS     (INDEX_BITS)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .conds       (conds),
    .step        (step),
    .idx         (feature_index),
    .value       (feature_value),
    .has_feature (has_feature),
    .last        (last),
    .res_set     (res_set),
    .res_covered (res_covered)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_set) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      covered <= res_covered;
    end
  end

endmodule
`default_nettype wire

>>> verif/conjunctive_rule_cover_check_tb.sv
`default_nettype none
module conjunctive_rule_cover_check_tb;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_BEATS   = 1900;

  typedef struct packed {
    logic [15:0] fidx;
    logic [31:0] fval;
    logic        has;
    logic        lst;
  } feat_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] feature_index;
  logic [31:0] feature_value;
  logic        has_feature;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic        covered;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_index;
  logic [63:0] cfg_data;

  conjunctive_rule_cover_check DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .feature_index(feature_index), .feature_value(feature_value),
    .has_feature(has_feature), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .covered(covered),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state: rule body and per-example verdict flags
  logic [crcc_pkg::REG_W-1:0] rule_word [crcc_pkg::NUM_REGS];
  logic [7:0]       seen_flags;
  logic [7:0]       pass_flags;

  feat_beat_t pending_beats[$];
  logic       expected_cover[$];

  int unsigned errors;
  int unsigned beats_in;
  int unsigned covers_out;
  int unsigned covers_true;
  int unsigned idle_cycles;
  bit          long_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ieee compare, nan passes leq, gt and neq; -0 equals +0
  function automatic logic rule_verdict(input logic [1:0] cmp, input logic [31:0] v,
                                        input logic [31:0] t);
    logic nan_any;
    logic eq;
    logic lt;
    nan_any = ((v[30:23] == 8'hff) && (v[22:0] != 0)) ||
              ((t[30:23] == 8'hff) && (t[22:0] != 0));
    eq = !nan_any && ((v == t) || (v[30:0] == 0 && t[30:0] == 0));
    if (nan_any || eq) lt = 1'b0;
    else if (v[31] != t[31]) lt = v[31];
    else if (v[31]) lt = t[30:0] < v[30:0];
    else lt = v[30:0] < t[30:0];
    case (cmp)
      crcc_pkg::CMP_LEQ: return nan_any || lt || eq;
      crcc_pkg::CMP_GT:  return nan_any || !(lt || eq);
      crcc_pkg::CMP_EQ:  return eq;
      default: return !eq;
    endcase
  endfunction

  // advance the predictor by one accepted beat
  task automatic predict_beat(input feat_beat_t b);
    logic ok;
    logic all_ok;
    if (b.has) begin
      for (int i = 0; i < crcc_pkg::NUM_REGS; i++) begin
        if (rule_word[i][50] && rule_word[i][47:32] == b.fidx) begin
          seen_flags[i] = 1'b1;
          pass_flags[i] = rule_verdict(rule_word[i][49:48], b.fval, rule_word[i][31:0]);
        end
      end
    end
    if (b.lst) begin
      all_ok = 1'b1;
      for (int i = 0; i < crcc_pkg::NUM_REGS; i++) begin
        if (rule_word[i][50]) begin
          ok = seen_flags[i] ? pass_flags[i]
                             : rule_verdict(rule_word[i][49:48], 32'h0, rule_word[i][31:0]);
          if (!ok) all_ok = 1'b0;
        end
      end
      expected_cover.push_back(all_ok);
      seen_flags = '0;
      pass_flags = '0;
    end
  endtask

  // feature driver: bursts with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_beat({feature_index, feature_value, has_feature, last});
        beats_in <= beats_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          feat_beat_t b;
          b = pending_beats.pop_front();
          {feature_index, feature_value, has_feature, last} <= b;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off to back the block up
  int unsigned stall_phase;
  int unsigned hold_count;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
      hold_count <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (long_hold && hold_count < 300) begin
        hold_count <= hold_count + 1;
        out_ready <= 1'b0;
      end else if (stall_phase[9:8] == 2'd0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      covers_out <= covers_out + 1;
      if (covered) covers_true <= covers_true + 1;
      if (expected_cover.size() == 0) begin
        $display("%0t: covered beat with nothing expected, actual %0b", $time, covered);
        errors <= errors + 1;
      end else begin
        logic want;
        want = expected_cover.pop_front();
        if (covered !== want) begin
          $display("%0t: covered mismatch, expected %0b actual %0b", $time, want, covered);
          errors <= errors + 1;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat or config write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("conjunctive_rule_cover_check test failed");
        $finish;
      end
    end
  end

  task automatic write_rule(input int unsigned ridx, input logic [63:0] word);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    if (ridx < crcc_pkg::NUM_REGS) rule_word[ridx[2:0]] = word[crcc_pkg::REG_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] make_rule(input logic en, input logic [1:0] cmp,
                                            input logic [15:0] fidx, input logic [31:0] thr);
    return {13'h0, en, cmp, fidx, thr};
  endfunction

  // thresholds and values drawn mostly from a small set of interesting floats
  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fc0_0000;
      3: return 32'h7f80_0000;
      4: return 32'hff80_0000;
      5: return 32'h3f80_0000;
      6: return 32'hbf80_0000;
      7: return 32'h0000_0001;
      8: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_cover.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic feat_beat_t make_beat(input logic [15:0] i, input logic [31:0] v,
                                           input logic h, input logic l);
    return {i, v, h, l};
  endfunction

  // one example: features at the rule's indices mostly, plus noise
  task automatic queue_example(input int unsigned nfeat);
    logic [15:0] idx;
    for (int k = 0; k < nfeat; k++) begin
      if ($urandom_range(0, 4) != 0) idx = rule_word[3'($urandom_range(0, 7))][47:32];
      else idx = 16'($urandom());
      pending_beats.push_back(make_beat(idx, ($urandom_range(0, 2) == 0) ? pick_float()
                                        : {1'($urandom_range(0, 1)), 8'h7f, 23'h0}
                                          | ($urandom() & 32'h00ff_ffff),
                                        ($urandom_range(0, 9) != 0), 1'b0));
    end
    pending_beats.push_back(make_beat(16'($urandom()), pick_float(),
                                      1'($urandom_range(0, 1)), 1'b1));
  endtask

  task automatic random_rule_set(input int unsigned idx_span);
    for (int i = 0; i < crcc_pkg::NUM_REGS; i++)
      write_rule(i, make_rule($urandom_range(0, 3) != 0, 2'($urandom_range(0, 3)),
                              16'($urandom_range(0, idx_span)), pick_float()));
  endtask

  int unsigned queued;
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    feature_index = '0;
    feature_value = '0;
    has_feature = 1'b0;
    last = 1'b0;
    out_ready = 1'b0;
    errors = 0; beats_in = 0; covers_out = 0; covers_true = 0; idle_cycles = 0;
    long_hold = 0; queued = 0;
    seen_flags = '0;
    pass_flags = '0;
    for (int i = 0; i < crcc_pkg::NUM_REGS; i++) rule_word[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // no enabled condition: covered, also on an empty last beat
    pending_beats.push_back(make_beat(16'h0, 32'h0, 1'b0, 1'b1));
    pending_beats.push_back(make_beat(16'hffff, 32'hffff_ffff, 1'b1, 1'b1));
    wait_drained();

    // rules on every comparator, index extremes, nan and signed zero thresholds
    write_rule(0, make_rule(1'b1, crcc_pkg::CMP_LEQ, 16'h0000, 32'h3f80_0000));
    write_rule(1, make_rule(1'b1, crcc_pkg::CMP_GT, 16'hffff, 32'hbf80_0000));
    write_rule(2, make_rule(1'b1, crcc_pkg::CMP_EQ, 16'h0005, 32'h8000_0000));
    write_rule(3, make_rule(1'b1, crcc_pkg::CMP_NEQ, 16'h0006, 32'h7fc0_0000));
    write_rule(4, make_rule(1'b0, crcc_pkg::CMP_EQ, 16'h0007, 32'h0));
    write_rule(5, make_rule(1'b1, crcc_pkg::CMP_LEQ, 16'h0008, 32'h7f80_0000));
    write_rule(6, make_rule(1'b1, crcc_pkg::CMP_GT, 16'h0009, 32'h7fc0_0000));
    write_rule(7, {13'h1fff, 1'b1, crcc_pkg::CMP_EQ, 16'h000a, 32'h0000_0000});
    write_rule(9, 64'hffff_ffff_ffff_ffff);
    // all missing: judged as +0.0
    pending_beats.push_back(make_beat(16'h1234, 32'h0, 1'b1, 1'b1));
    // repeated index, later value wins; nan values
    pending_beats.push_back(make_beat(16'h0000, 32'h4000_0000, 1'b1, 1'b0));
    pending_beats.push_back(make_beat(16'h0000, 32'hbf80_0000, 1'b1, 1'b0));
    pending_beats.push_back(make_beat(16'hffff, 32'hffc0_0001, 1'b1, 1'b0));
    pending_beats.push_back(make_beat(16'h0005, 32'h0000_0000, 1'b1, 1'b0));
    pending_beats.push_back(make_beat(16'h0006, 32'h7fc0_0000, 1'b1, 1'b0));
    pending_beats.push_back(make_beat(16'h0008, 32'hff80_0000, 1'b1, 1'b0));
    pending_beats.push_back(make_beat(16'h000a, 32'h8000_0000, 1'b0, 1'b1));
    pending_beats.push_back(make_beat(16'h0005, 32'h7fc0_0000, 1'b1, 1'b0));
    pending_beats.push_back(make_beat(16'h000a, 32'h8000_0000, 1'b1, 1'b1));
    pending_beats.push_back(make_beat(16'h0000, 32'h3f80_0000, 1'b1, 1'b1));
    wait_drained();

    // random phases over several rule sets; one phase with a long receiver hold-off
    for (int ph = 0; queued < RANDOM_BEATS; ph++) begin
      random_rule_set((ph % 3 == 0) ? 65535 : 15);
      if (ph == 2) long_hold = 1;
      for (int e = 0; e < 30; e++) begin
        queue_example($urandom_range(0, (e % 10 == 0) ? 20 : 5));
      end
      queued += pending_beats.size();
      wait_drained();
    end
    // disable everything again to finish on the low extreme
    for (int i = 0; i < crcc_pkg::NUM_REGS; i++) write_rule(i, 64'h0);
    queue_example(3);
    wait_drained();

    $display("%0d feature beats, %0d covered results (%0d true) over several rule sets",
             beats_in, covers_out, covers_true);
    if (errors == 0) begin
      $display("conjunctive_rule_cover_check test passed");
    end else begin
      $display("conjunctive_rule_cover_check test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
design/crcc_pkg.sv
design/crcc_cfg_regs.sv
design/crcc_match.sv
design/conjunctive_rule_cover_check.sv
verif/conjunctive_rule_cover_check_tb.sv
